### rtl/acvfc_pkg.sv
// Package for the AES-256 CTR voice frame cipher: shared types, constants,
// the S-box and the round helper functions. No dependencies.
package acvfc_pkg;

	localparam int FrameBytes = 27;
	localparam logic [23:0] FrameLimit = 24'd10000000;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_KEY0  = 3'd0,
		REG_KEY1  = 3'd1,
		REG_KEY2  = 3'd2,
		REG_KEY3  = 3'd3,
		REG_NONCE = 3'd4
	} reg_t;

	// Work item handed from the front end to the back end.
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       was_ciphered;
		logic       session_on;
		logic       frame_last;
	} result_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [0:255];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a 128-bit block sits in bits 127-8i down to 120-8i.
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
		logic [7:0] t [0:15];
		logic [7:0] a0, a1, a2, a3, x;
		logic [127:0] r;
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[4*c+i] = sbox(s[127-8*(4*((c+i)%4)+i) -: 8]);
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			x = a0 ^ a1 ^ a2 ^ a3;
			if (!last) begin
				t[4*c]   = a0 ^ x ^ xt(a0 ^ a1);
				t[4*c+1] = a1 ^ x ^ xt(a1 ^ a2);
				t[4*c+2] = a2 ^ x ^ xt(a2 ^ a3);
				t[4*c+3] = a3 ^ x ^ xt(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[127-8*i -: 8] = t[i];
		end
		return r;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

endpackage

### rtl/acvfc_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module acvfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/acvfc_front.sv
// Front end: accepts input transactions and queues them for the back end.
// Depends on acvfc_pkg.
module acvfc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  acvfc_pkg::item_t    in_item,
	output logic                q_valid,
	input  logic                q_ready,
	output acvfc_pkg::item_t    q_item
);
	acvfc_pkg::item_t mem_q [0:1];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### rtl/acvfc_back.sv
// Back end: key expansion, frame keystream generation and byte XOR.
// Depends on acvfc_pkg and acvfc_ram.
module acvfc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [255:0]         key,
	input  logic [63:0]          nonce,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  acvfc_pkg::item_t     q_item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output acvfc_pkg::result_t   res
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_KEYX, ST_RK, ST_ENC, ST_KSR, ST_OUT
	} bst_t;

	bst_t         st_q, st_d;
	logic         active_q, clear_q;
	logic [23:0]  fcnt_q;
	logic [4:0]   pos_q;
	logic [255:0] kw_q;
	logic [5:0]   wi_q;
	logic [3:0]   rnd_q;
	logic         blk_q;
	logic [127:0] s_q;
	logic [127:0] rk_rd;
	logic [127:0] rk_wdata;
	logic [3:0]   rk_waddr, rk_raddr;
	logic         rk_we, ks_we;
	logic [4:0]   ks_waddr;
	logic [7:0]   ks_rd;
	logic [7:0]   ks_wdata;
	logic [7:0]   d_q;
	logic [127:0] ksbuf_q;
	logic [127:0] fin;
	logic [3:0]   kb_q;
	logic [31:0]  tw, nw;
	logic [7:0]   rc;
	logic         fst;
	logic         d_q_is_byte;
	logic [1:0]   op_q;

	acvfc_ram #(.WIDTH(128), .DEPTH(16)) u_rk (
		.clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
		.raddr(rk_raddr), .rdata(rk_rd));

	acvfc_ram #(.WIDTH(8), .DEPTH(32)) u_ks (
		.clk(clk), .we(ks_we), .waddr(ks_waddr), .wdata(ks_wdata),
		.raddr(pos_q), .rdata(ks_rd));

	always_comb begin
		case (wi_q[5:3])
			3'd1: rc = 8'h01;
			3'd2: rc = 8'h02;
			3'd3: rc = 8'h04;
			3'd4: rc = 8'h08;
			3'd5: rc = 8'h10;
			3'd6: rc = 8'h20;
			3'd7: rc = 8'h40;
			default: rc = 8'h00;
		endcase
		tw = kw_q[31:0];
		if (wi_q[2:0] == 3'd0) begin
			tw = acvfc_pkg::sub_word({tw[23:0], tw[31:24]}) ^ {rc, 24'd0};
		end else if (wi_q[2:0] == 3'd4) begin
			tw = acvfc_pkg::sub_word(tw);
		end
		nw = kw_q[255:224] ^ tw;
	end

	assign fst = (pos_q == 5'd0);
	assign rk_wdata = (wi_q == 6'd0) ? kw_q[255:128] : kw_q[127:0];
	assign rk_waddr = (st_q == ST_RK) ? 4'((wi_q - 6'd4) >> 2) : 4'd0;
	assign ks_waddr = {blk_q, kb_q};
	assign fin      = acvfc_pkg::aes_round(s_q, 1'b1) ^ rk_rd;
	assign ks_wdata = (kb_q == 4'd0) ? fin[127 -: 8] : ksbuf_q[127 -: 8];

	always_comb begin
		st_d     = st_q;
		q_ready  = 1'b0;
		res_valid = (st_q == ST_OUT);
		rk_we    = 1'b0;
		ks_we    = 1'b0;
		rk_raddr = rnd_q;
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_item.op)
						acvfc_pkg::OP_START: st_d = ST_KEYX;
						acvfc_pkg::OP_BYTE: begin
							if (fst && active_q && fcnt_q < acvfc_pkg::FrameLimit) begin
								st_d = ST_ENC;
							end else begin
								st_d = ST_KSR;
							end
						end
						default: st_d = ST_OUT;
					endcase
				end
			end
			ST_KEYX: begin
				rk_we = 1'b1;
				st_d = ST_RK;
			end
			ST_RK: begin
				rk_we = (wi_q[1:0] == 2'd0);
				if (wi_q == 6'd60) st_d = ST_OUT;
			end
			ST_ENC: begin
				ks_we = (kb_q != 4'd0) || (rnd_q == 4'd15);
				if (kb_q == 4'd15 && blk_q) st_d = ST_KSR;
			end
			ST_KSR: st_d = ST_OUT;
			ST_OUT: begin
				if (res_ready) begin
					q_ready = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			active_q <= 1'b0;
			clear_q  <= 1'b0;
			fcnt_q   <= 24'd0;
			pos_q    <= 5'd0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_IDLE && q_valid) begin
				case (q_item.op)
					acvfc_pkg::OP_START: begin
						active_q <= 1'b1;
						fcnt_q   <= 24'd0;
						pos_q    <= 5'd0;
					end
					acvfc_pkg::OP_STOP: begin
						active_q <= 1'b0;
						fcnt_q   <= 24'd0;
						pos_q    <= 5'd0;
					end
					acvfc_pkg::OP_BYTE: begin
						if (fst) begin
							if (!active_q) begin
								clear_q <= 1'b1;
							end else if (fcnt_q >= acvfc_pkg::FrameLimit) begin
								active_q <= 1'b0;
								clear_q  <= 1'b1;
							end else begin
								clear_q <= 1'b0;
							end
						end
					end
					default: ;
				endcase
			end
			if (st_q == ST_ENC && st_d == ST_KSR) begin
				fcnt_q <= fcnt_q + 24'd1;
			end
			if (st_q == ST_OUT && res_ready && res.frame_last) begin
				pos_q <= 5'd0;
			end else if (st_q == ST_OUT && res_ready && d_q_is_byte) begin
				pos_q <= pos_q + 5'd1;
			end
		end
	end

	assign d_q_is_byte = (op_q == acvfc_pkg::OP_BYTE);

	// Encryption: rnd_q counts the round key read; s_q is applied the
	// key that arrives in the cycle after its address.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				op_q  <= q_item.op;
				d_q   <= q_item.data;
				kw_q  <= key;
				wi_q  <= 6'd0;
				rnd_q <= 4'd0;
				blk_q <= 1'b0;
				kb_q  <= 4'd0;
				s_q   <= {nonce, 8'd0, fcnt_q, 32'd0};
			end
			ST_KEYX: wi_q <= 6'd8;
			ST_RK: begin
				kw_q <= {kw_q[223:0], nw};
				wi_q <= wi_q + 6'd1;
			end
			ST_ENC: begin
				if (kb_q != 4'd0) begin
					ksbuf_q <= {ksbuf_q[119:0], 8'd0};
					kb_q <= kb_q + 4'd1;
					if (kb_q == 4'd15) begin
						blk_q <= 1'b1;
						rnd_q <= 4'd0;
						s_q <= {nonce, 8'd0, fcnt_q, 32'd1};
					end
				end else if (rnd_q == 4'd15) begin
					ksbuf_q <= {fin[119:0], 8'd0};
					kb_q <= 4'd1;
				end else begin
					if (rnd_q != 4'd0) begin
						if (rnd_q == 4'd1) begin
							s_q <= s_q ^ rk_rd;
						end else begin
							s_q <= acvfc_pkg::aes_round(s_q, rnd_q == 4'd15) ^ rk_rd;
						end
					end
					rnd_q <= rnd_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res = '0;
		res.session_on = active_q;
		if (d_q_is_byte) begin
			res.frame_last   = (32'(pos_q) + 1 >= acvfc_pkg::FrameBytes);
			res.was_ciphered = !clear_q;
			res.data_out     = clear_q ? d_q : (d_q ^ ks_rd);
		end
	end
endmodule

### rtl/aes256_ctr_voice_frame_cipher.sv
// Top level of the AES-256 CTR voice frame cipher: configuration registers,
// front queue and back end. Depends on acvfc_pkg, acvfc_front, acvfc_back.
//
// Voice bytes and control operations arrive on the slave stream, the op in
// s_tuser and the byte in s_tdata. Each input transaction yields exactly one
// result transaction on the master stream, in order. The configuration
// channel writes the four key words and the nonce; cfg_ready is always high,
// and writes should only be made while no transaction is in flight.
// A byte that needs no new keystream passes through a keystream read state
// to the result; the first byte of a ciphered frame first runs two AES
// blocks at one round per cycle plus byte writes; a start runs key
// expansion at one word per cycle; a stop or an unused op goes straight to
// the result. The back end returns to idle once its result is taken and
// handles one item at a time, taking the next only from idle.
// A two-entry queue decouples the input: when the receiver stalls, the back
// end holds its result, the queue fills and s_tready falls.
// Reset clears the registers, empties the queue and leaves the session off.
module aes256_ctr_voice_frame_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // op
	input  logic [7:0]  s_tdata,  // data_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // data_out, session_on
	output logic        m_tuser,  // was_ciphered
	output logic        m_tlast   // frame_last
);
	logic [63:0] k0_q, k1_q, k2_q, k3_q, n_q;
	logic        q_valid, q_ready;
	acvfc_pkg::item_t   in_item, q_item;
	acvfc_pkg::result_t res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k0_q <= '0; k1_q <= '0; k2_q <= '0; k3_q <= '0; n_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				acvfc_pkg::REG_KEY0:  k0_q <= cfg_data;
				acvfc_pkg::REG_KEY1:  k1_q <= cfg_data;
				acvfc_pkg::REG_KEY2:  k2_q <= cfg_data;
				acvfc_pkg::REG_KEY3:  k3_q <= cfg_data;
				acvfc_pkg::REG_NONCE: n_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_item = {acvfc_pkg::op_t'(s_tuser), s_tdata};

	acvfc_front u_front (.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item));

	acvfc_back u_back (.clk(clk), .arst_n(arst_n), .key({k0_q, k1_q, k2_q, k3_q}),
		.nonce(n_q), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(res));

	assign m_tdata = {7'd0, res.session_on, res.data_out};
	assign m_tuser = res.was_ciphered;
	assign m_tlast = res.frame_last;
endmodule
